// ===== rtl/ptrk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ptrk_pkg;

    localparam int CHANNELS   = 8;
    localparam int COUNT_BITS = 16;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // one memory word per channel
    localparam int DIV_W  = 32;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [15:0] ERR_VALUE = 16'hFC18;  // -1000

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_CH = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [31:0]           sum;
        logic [15:0]           hi;
        logic [15:0]           lo;
        logic [15:0]           last;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== rtl/per_channel_min_max_mean_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Running statistics for each sensor channel: current, minimum, truncated mean and
// maximum. Requests are taken one at a time. An add or read on a valid channel goes
// through a memory read, an update, then a bit-serial divide of the sum by the
// count; a clear or a bad channel goes straight to the result.
// The divider sets the rate. Each channel's statistics sit in one memory word and its
// valid bit in a register; a clear request empties every channel at once. The next
// request is accepted while a finished result still waits in the output register.
module per_channel_min_max_mean_tracker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // channel[3:0], sample_value[19:4], zero fill
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // current[15:0], minimum[31:16], mean[47:32],
                                        // maximum[63:48]
    output logic [1:0]       m_tuser    // status[1:0]
);

    localparam int CB   = ptrk_pkg::COUNT_BITS;
    localparam int CHW  = ptrk_pkg::CH_W;
    localparam int DW   = ptrk_pkg::DIV_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_DIV,
        S_DONE
    } state_t;

    state_t         state_reg;
    logic [1:0]     op_reg;
    logic [3:0]     ch_reg;
    logic [15:0]    smp_reg;
    logic [15:0]    cur_reg;
    logic [15:0]    lo_reg;
    logic [15:0]    hi_reg;
    logic [15:0]    mean_reg;
    logic [31:0]    sum_reg;
    logic [CB-1:0]  cnt_reg;
    logic [1:0]     status_reg;
    logic [ptrk_pkg::CHANNELS-1:0] valid_reg;
    logic           m_valid_reg;
    logic [63:0]    m_data_reg;
    logic [1:0]     m_user_reg;

    logic                       in_fire;
    logic [3:0]                 in_ch;
    logic                       in_bad;
    logic [ptrk_pkg::ENTRY_W-1:0] ram_rdata;
    ptrk_pkg::entry_t           ent;
    ptrk_pkg::entry_t           upd;
    logic                       ram_we;
    logic                       first;
    logic [32:0]                nsum;
    logic                       sum_ovf;
    logic                       take;
    logic                       div_start;
    logic [DW-1:0]              div_dividend;
    logic                       div_done;
    logic [DW-1:0]              div_quo;
    logic [DW-1:0]              mean_full;
    logic                       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_ch    = s_tdata[3:0];
    assign in_bad   = {1'b0, in_ch} >= ptrk_pkg::CH_LIMIT;
    assign out_free = !m_valid_reg || m_tready;

    ptrk_ram #(
        .WIDTH(ptrk_pkg::ENTRY_W),
        .DEPTH(ptrk_pkg::CHANNELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ch_reg[CHW-1:0]),
        .wdata (upd),
        .raddr (in_ch[CHW-1:0]),
        .rdata (ram_rdata)
    );

    // entry update for an add; a never-written entry reads as empty
    always_comb begin
        ent      = valid_reg[ch_reg[CHW-1:0]] ? ptrk_pkg::entry_t'(ram_rdata)
                                              : ptrk_pkg::entry_t'('0);
        first    = (ent.count == '0);
        nsum     = {ent.sum[31], ent.sum} + {{17{smp_reg[15]}}, smp_reg};
        sum_ovf  = (nsum[32] != nsum[31]);
        take     = (ent.count != ptrk_pkg::COUNT_MAX) && !sum_ovf;
        upd      = ent;
        if (op_reg == ptrk_pkg::OP_ADD) begin
            upd.last = smp_reg;
            if (first || ($signed(smp_reg) < $signed(ent.lo))) begin
                upd.lo = smp_reg;
            end
            if (first || ($signed(smp_reg) > $signed(ent.hi))) begin
                upd.hi = smp_reg;
            end
            if (take) begin
                upd.sum   = nsum[31:0];
                upd.count = ent.count + CB'(1);
            end
        end
        ram_we = (state_reg == S_READ) && (op_reg == ptrk_pkg::OP_ADD);
    end

    assign div_start    = (state_reg == S_START);
    assign div_dividend = sum_reg[31] ? (32'd0 - sum_reg) : sum_reg;
    assign mean_full    = sum_reg[31] ? (32'd0 - div_quo) : div_quo;

    ptrk_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (m_valid_reg && m_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        op_reg  <= s_tuser;
                        ch_reg  <= in_ch;
                        smp_reg <= s_tdata[19:4];
                        if (s_tuser == ptrk_pkg::OP_CLEAR) begin
                            valid_reg  <= '0;
                            cur_reg    <= '0;
                            lo_reg     <= '0;
                            mean_reg   <= '0;
                            hi_reg     <= '0;
                            status_reg <= ptrk_pkg::ST_OK;
                            state_reg  <= S_DONE;
                        end else if (in_bad) begin
                            cur_reg    <= ptrk_pkg::ERR_VALUE;
                            lo_reg     <= ptrk_pkg::ERR_VALUE;
                            mean_reg   <= ptrk_pkg::ERR_VALUE;
                            hi_reg     <= ptrk_pkg::ERR_VALUE;
                            status_reg <= ptrk_pkg::ST_BAD_CH;
                            state_reg  <= S_DONE;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (ram_we) begin
                        valid_reg[ch_reg[CHW-1:0]] <= 1'b1;
                    end
                    sum_reg <= upd.sum;
                    cnt_reg <= upd.count;
                    if (upd.count == '0) begin
                        cur_reg    <= '0;
                        lo_reg     <= '0;
                        mean_reg   <= '0;
                        hi_reg     <= '0;
                        status_reg <= ptrk_pkg::ST_EMPTY;
                        state_reg  <= S_DONE;
                    end else begin
                        cur_reg    <= upd.last;
                        lo_reg     <= upd.lo;
                        hi_reg     <= upd.hi;
                        status_reg <= ptrk_pkg::ST_OK;
                        state_reg  <= S_START;
                    end
                end
                S_START: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        mean_reg  <= mean_full[15:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {hi_reg, mean_reg, lo_reg, cur_reg};
                        m_user_reg  <= status_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // a bad channel reports the error value everywhere
    a_bad_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ptrk_pkg::ST_BAD_CH) |->
        (m_tdata == {4{ptrk_pkg::ERR_VALUE}}))
        else $error("bad channel result with wrong fields");

    // an empty channel reports zeros
    a_empty_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ptrk_pkg::ST_EMPTY) |-> (m_tdata == 64'd0))
        else $error("empty channel result not zero");

    // mean and current lie between minimum and maximum
    a_mean_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ptrk_pkg::ST_OK) |->
        ($signed(m_tdata[31:16]) <= $signed(m_tdata[47:32]) &&
         $signed(m_tdata[47:32]) <= $signed(m_tdata[63:48]) &&
         $signed(m_tdata[31:16]) <= $signed(m_tdata[15:0]) &&
         $signed(m_tdata[15:0]) <= $signed(m_tdata[63:48])))
        else $error("statistics out of order");

    // memory is written only for an add on a real channel
    a_write_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ({1'b0, ch_reg} < ptrk_pkg::CH_LIMIT))
        else $error("memory write for a bad channel");

    // a clear request empties every channel
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser == ptrk_pkg::OP_CLEAR) |=> (valid_reg == '0))
        else $error("clear left a channel populated");

endmodule
`default_nettype wire

// ===== rtl/ptrk_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptrk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/ptrk_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ptrk_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [ptrk_pkg::DIV_W-1:0]      dividend,
    input  wire logic [ptrk_pkg::COUNT_BITS-1:0] divisor,
    output logic                                 done,
    output logic [ptrk_pkg::DIV_W-1:0]           quotient
);

    localparam int CB = ptrk_pkg::COUNT_BITS;
    localparam int DW = ptrk_pkg::DIV_W;
    localparam int SW = ptrk_pkg::STEP_W;

    logic [DW-1:0] quo_reg;
    logic [CB-1:0] rem_reg;
    logic [CB-1:0] dvs_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [CB:0] shifted;
    logic [CB:0] diff;
    logic        ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = shifted >= {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                quo_reg  <= {quo_reg[DW-2:0], ge};
                rem_reg  <= ge ? diff[CB-1:0] : shifted[CB-1:0];
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire
